// ===== rtl/sscp_pkg.sv =====
// Shared constants and types for the segment closest-points unit.
package sscp_pkg;

  localparam int DEF_COORD_BITS      = 24;
  localparam int DEF_PARAM_FRAC_BITS = 16;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DEGENERATE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_LIMIT   = 1'd1;

  localparam logic [CFG_W-1:0] DEGENERATE_LIMIT_RST = 16'd1;
  localparam logic [CFG_W-1:0] PARALLEL_LIMIT_RST   = 16'd1;

  // Which of the two segments collapses to a point.
  typedef struct packed {
    logic pt1;
    logic pt2;
  } deg_flags_t;

endpackage

// ===== rtl/sscp_delay.sv =====
// Fixed-length register delay line used to keep side data aligned with the datapath.
module sscp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < N; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];

endmodule

// ===== rtl/sscp_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module sscp_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH-1:0] ah;
  logic signed [AL:0]   al;
  logic signed [BH-1:0] bh;
  logic signed [BL:0]   bl;

  logic signed [AH+BH-1:0]   hh;
  logic signed [AH+BL:0]     hl;
  logic signed [AL+BH:0]     lh;
  logic signed [AL+BL+1:0]   ll;

  assign ah = $signed(a[AW-1:AL]);
  assign al = $signed({1'b0, a[AL-1:0]});
  assign bh = $signed(b[BW-1:BL]);
  assign bl = $signed({1'b0, b[BL-1:0]});

  always_ff @(posedge clk) begin
    hh <= ah * bh;
    hl <= ah * bl;
    lh <= al * bh;
    ll <= al * bl;
  end

  always_ff @(posedge clk) begin
    p <= (PW'(hh) <<< (AL + BL)) + (PW'(hl) <<< AL) + (PW'(lh) <<< BL) + PW'(ll);
  end

endmodule

// ===== rtl/sscp_div.sv =====
// Pipelined restoring divider giving num/den clamped to [0,1] as an unsigned fraction.
module sscp_div #(
  parameter int NW = 16,
  parameter int QB = 16
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic [QB:0]          quo
);

  logic [NW-1:0] rem     [QB+1];
  logic [NW-1:0] dv      [QB+1];
  logic [QB-1:0] qa      [QB+1];
  logic          is_zero [QB+1];
  logic          is_one  [QB+1];

  // The clamp cases are decided up front; the quotient bits are only used otherwise.
  always_ff @(posedge clk) begin
    rem[0]     <= num;
    dv[0]      <= den;
    qa[0]      <= '0;
    is_zero[0] <= (num <= $signed(NW'(0)));
    is_one[0]  <= (num >= den);
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NW:0] sh;
    logic        ge;

    assign sh = {rem[k-1], 1'b0};
    assign ge = (sh >= {1'b0, dv[k-1]});

    always_ff @(posedge clk) begin
      rem[k]     <= ge ? NW'(sh - {1'b0, dv[k-1]}) : NW'(sh);
      dv[k]      <= dv[k-1];
      qa[k]      <= {qa[k-1][QB-2:0], ge};
      is_zero[k] <= is_zero[k-1];
      is_one[k]  <= is_one[k-1];
    end
  end

  always_comb begin
    if (is_zero[QB]) begin
      quo = '0;
    end else if (is_one[QB]) begin
      quo = (QB+1)'(1) << QB;
    end else begin
      quo = {1'b0, qa[QB]};
    end
  end

endmodule

// ===== rtl/segment_segment_closest_points_unit.sv =====
// Top level of the pipelined closest-points unit for two 3D line segments.
//
// Usage: drive the twelve endpoint coordinates and raise start; an item is
// taken on every rising edge where start is high and busy is low. busy is
// high only while rst is asserted, so one item can enter every cycle.
// Each item produces exactly one result: done is high for one cycle with
// param_s, param_t, the two nearest points and dist_sq on the result ports.
// Throughput is one item per cycle. The pipeline length is set by the
// two pipelined dividers, one stage per quotient bit, which run one
// after the other: t depends on the first value of s.
// Results come out in the order items went in. The receiver cannot stall,
// so no result is ever held back.
// The two limit registers are written through cfg_we/cfg_index/cfg_data
// and are read throughout the pipeline, so write them only while no item
// is in flight. A synchronous reset clears the item pipeline and sets
// both limits to one; items in flight at reset are dropped.
module segment_segment_closest_points_unit #(
  parameter int COORD_BITS      = sscp_pkg::DEF_COORD_BITS,
  parameter int PARAM_FRAC_BITS = sscp_pkg::DEF_PARAM_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [sscp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sscp_pkg::CFG_W-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0]      p1_x,
  input  logic signed [COORD_BITS-1:0]      p1_y,
  input  logic signed [COORD_BITS-1:0]      p1_z,
  input  logic signed [COORD_BITS-1:0]      q1_x,
  input  logic signed [COORD_BITS-1:0]      q1_y,
  input  logic signed [COORD_BITS-1:0]      q1_z,
  input  logic signed [COORD_BITS-1:0]      p2_x,
  input  logic signed [COORD_BITS-1:0]      p2_y,
  input  logic signed [COORD_BITS-1:0]      p2_z,
  input  logic signed [COORD_BITS-1:0]      q2_x,
  input  logic signed [COORD_BITS-1:0]      q2_y,
  input  logic signed [COORD_BITS-1:0]      q2_z,
  output logic                              done,
  output logic [PARAM_FRAC_BITS:0]          param_s,
  output logic [PARAM_FRAC_BITS:0]          param_t,
  output logic signed [COORD_BITS-1:0]      near1_x,
  output logic signed [COORD_BITS-1:0]      near1_y,
  output logic signed [COORD_BITS-1:0]      near1_z,
  output logic signed [COORD_BITS-1:0]      near2_x,
  output logic signed [COORD_BITS-1:0]      near2_y,
  output logic signed [COORD_BITS-1:0]      near2_z,
  output logic [2*COORD_BITS+1:0]           dist_sq
);

  import sscp_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int P      = PARAM_FRAC_BITS;
  localparam int DW     = CB + 1;
  localparam int PW     = 2 * DW;
  localparam int DOT_W  = PW + 2;
  localparam int MUL_W  = 2 * DOT_W;
  localparam int WIDE_W = MUL_W + 1;
  localparam int NA_W   = DOT_W + 1;
  localparam int SW     = P + 1;
  localparam int TN_W   = DOT_W + SW + 1;
  localparam int SP_W   = DW + SW + 1;
  localparam int SUM_W  = PW + 2;
  localparam int DIST_W = 2 * CB + 2;

  // Stage numbers: D is where the first dividers finish, F holds final s and t.
  localparam int D   = P + 7;
  localparam int F   = 2 * P + 13;
  localparam int TOT = F + 5;

  localparam logic [SW-1:0] ONE = SW'(1) << P;

  // Configuration.
  logic [CFG_W-1:0] deg_limit;
  logic [CFG_W-1:0] par_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_limit <= DEGENERATE_LIMIT_RST;
      par_limit <= PARALLEL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGENERATE_LIMIT: deg_limit <= cfg_data;
        REG_PARALLEL_LIMIT:   par_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the datapath.
  logic           accept;
  logic [TOT-1:0] vld;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOT-2:0], accept};
    end
  end

  assign done = vld[TOT-1];

  // Stage 1: edge vectors.
  logic signed [CB-1:0] in_p1 [3];
  logic signed [CB-1:0] in_q1 [3];
  logic signed [CB-1:0] in_p2 [3];
  logic signed [CB-1:0] in_q2 [3];

  assign in_p1 = '{p1_x, p1_y, p1_z};
  assign in_q1 = '{q1_x, q1_y, q1_z};
  assign in_p2 = '{p2_x, p2_y, p2_z};
  assign in_q2 = '{q2_x, q2_y, q2_z};

  logic signed [CB-1:0] p1_r [3];
  logic signed [CB-1:0] p2_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] r_r  [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p1_r[k] <= in_p1[k];
      p2_r[k] <= in_p2[k];
      d1_r[k] <= DW'(in_q1[k]) - DW'(in_p1[k]);
      d2_r[k] <= DW'(in_q2[k]) - DW'(in_p2[k]);
      r_r[k]  <= DW'(in_p1[k]) - DW'(in_p2[k]);
    end
  end

  // Stage 2: component products of the five dot products.
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pe [3];
  logic signed [PW-1:0] pb [3];
  logic signed [PW-1:0] pc [3];
  logic signed [PW-1:0] pf [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pa[k] <= d1_r[k] * d1_r[k];
      pe[k] <= d2_r[k] * d2_r[k];
      pb[k] <= d1_r[k] * d2_r[k];
      pc[k] <= d1_r[k] * r_r[k];
      pf[k] <= d2_r[k] * r_r[k];
    end
  end

  // Stage 3: dot products.
  logic signed [DOT_W-1:0] a_r, e_r, b_r, c_r, f_r;

  always_ff @(posedge clk) begin
    a_r <= DOT_W'(pa[0]) + DOT_W'(pa[1]) + DOT_W'(pa[2]);
    e_r <= DOT_W'(pe[0]) + DOT_W'(pe[1]) + DOT_W'(pe[2]);
    b_r <= DOT_W'(pb[0]) + DOT_W'(pb[1]) + DOT_W'(pb[2]);
    c_r <= DOT_W'(pc[0]) + DOT_W'(pc[1]) + DOT_W'(pc[2]);
    f_r <= DOT_W'(pf[0]) + DOT_W'(pf[1]) + DOT_W'(pf[2]);
  end

  logic signed [DOT_W-1:0] deg_ext;
  deg_flags_t              deg_c;
  logic signed [NA_W-1:0]  na_c, nb_c;

  assign deg_ext   = $signed({{(DOT_W-CFG_W){1'b0}}, deg_limit});
  assign deg_c.pt1 = (a_r <= deg_ext);
  assign deg_c.pt2 = (e_r <= deg_ext);
  assign na_c      = -NA_W'(c_r);
  assign nb_c      = NA_W'(b_r) - NA_W'(c_r);

  // Stages 4-5: wide products for the denominator and the s numerator.
  logic signed [MUL_W-1:0] ae_m, bb_m, bf_m, ce_m;

  sscp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ae (.clk(clk), .a(a_r), .b(e_r), .p(ae_m));
  sscp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bb (.clk(clk), .a(b_r), .b(b_r), .p(bb_m));
  sscp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bf (.clk(clk), .a(b_r), .b(f_r), .p(bf_m));
  sscp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ce (.clk(clk), .a(c_r), .b(e_r), .p(ce_m));

  // Stage 6: denominator and numerator of the unclamped s.
  logic signed [WIDE_W-1:0] denom_r, snum_r;

  always_ff @(posedge clk) begin
    denom_r <= WIDE_W'(ae_m) - WIDE_W'(bb_m);
    snum_r  <= WIDE_W'(bf_m) - WIDE_W'(ce_m);
  end

  logic                    ok_c;
  logic signed [WIDE_W-1:0] par_ext;

  assign par_ext = $signed({{(WIDE_W-CFG_W){1'b0}}, par_limit});
  assign ok_c    = (denom_r != '0) && !denom_r[WIDE_W-1] && (denom_r >= par_ext);

  // Side operands brought to stage 6.
  logic [2*NA_W-1:0]       nab_d;
  logic signed [DOT_W-1:0] a_d6, f_d6, e_d6;
  logic [3*DOT_W-1:0]      afe_d;

  sscp_delay #(.W(2*NA_W), .N(3)) u_dl_nab (.clk(clk), .d({na_c, nb_c}), .q(nab_d));
  sscp_delay #(.W(3*DOT_W), .N(3)) u_dl_afe (.clk(clk), .d({a_r, f_r, e_r}), .q(afe_d));

  assign a_d6 = $signed(afe_d[3*DOT_W-1:2*DOT_W]);
  assign f_d6 = $signed(afe_d[2*DOT_W-1:DOT_W]);
  assign e_d6 = $signed(afe_d[DOT_W-1:0]);

  // Stages 7 to D: four dividers side by side.
  logic [SW-1:0] s0_q, sa_q, sb_q, te_q;

  sscp_div #(.NW(WIDE_W), .QB(P)) u_div_s (
    .clk(clk), .num(snum_r), .den(denom_r), .quo(s0_q)
  );
  sscp_div #(.NW(NA_W), .QB(P)) u_div_a (
    .clk(clk), .num($signed(nab_d[2*NA_W-1:NA_W])), .den(NA_W'(a_d6)), .quo(sa_q)
  );
  sscp_div #(.NW(NA_W), .QB(P)) u_div_b (
    .clk(clk), .num($signed(nab_d[NA_W-1:0])), .den(NA_W'(a_d6)), .quo(sb_q)
  );
  sscp_div #(.NW(DOT_W), .QB(P)) u_div_e (
    .clk(clk), .num(f_d6), .den(e_d6), .quo(te_q)
  );

  deg_flags_t deg_d;
  logic       ok_d;

  sscp_delay #(.W(2), .N(D-3)) u_dl_deg (.clk(clk), .d(deg_c), .q(deg_d));
  sscp_delay #(.W(1), .N(D-6)) u_dl_ok (.clk(clk), .d(ok_c), .q(ok_d));

  // Stage D+1: first choice of s.
  logic [SW-1:0] s_mid_r, sa_r, sb_r, te_r;
  deg_flags_t    deg_r;

  always_ff @(posedge clk) begin
    if (deg_d.pt1) begin
      s_mid_r <= '0;
    end else if (deg_d.pt2) begin
      s_mid_r <= sa_q;
    end else begin
      s_mid_r <= ok_d ? s0_q : '0;
    end
    sa_r  <= sa_q;
    sb_r  <= sb_q;
    te_r  <= te_q;
    deg_r <= deg_d;
  end

  // Stages D+2 to D+4: numerator of t is b*s + f.
  logic signed [DOT_W-1:0] b_d, f_d, e_d;
  logic signed [TN_W-1:0]  bs_m;

  sscp_delay #(.W(DOT_W), .N(D-2)) u_dl_b (.clk(clk), .d(b_r), .q(b_d));
  sscp_delay #(.W(DOT_W), .N(D))   u_dl_f (.clk(clk), .d(f_r), .q(f_d));
  sscp_delay #(.W(DOT_W), .N(D+1)) u_dl_e (.clk(clk), .d(e_r), .q(e_d));

  sscp_mul #(.AW(DOT_W), .BW(SW+1)) u_mul_bs (
    .clk(clk), .a(b_d), .b($signed({1'b0, s_mid_r})), .p(bs_m)
  );

  logic signed [TN_W-1:0] tnom_r, eq_c;

  always_ff @(posedge clk) begin
    tnom_r <= bs_m + (TN_W'(f_d) <<< P);
  end

  assign eq_c = TN_W'(e_d) <<< P;

  logic [1:0] tcls_c, tcls_d;

  assign tcls_c = {tnom_r[TN_W-1], (tnom_r > eq_c)};

  logic [SW-1:0] tq;

  sscp_div #(.NW(TN_W), .QB(P)) u_div_t (.clk(clk), .num(tnom_r), .den(eq_c), .quo(tq));

  sscp_delay #(.W(2), .N(P+1)) u_dl_tcls (.clk(clk), .d(tcls_c), .q(tcls_d));

  logic [2+4*SW-1:0] mid_d;
  deg_flags_t        deg_m;
  logic [SW-1:0]     smid_m, sa_m, sb_m, te_m;

  sscp_delay #(.W(2+4*SW), .N(P+4)) u_dl_mid (
    .clk(clk), .d({deg_r, s_mid_r, sa_r, sb_r, te_r}), .q(mid_d)
  );

  assign {deg_m, smid_m, sa_m, sb_m, te_m} = mid_d;

  // Stage F: final s and t, with s solved again when t was clamped.
  logic [SW-1:0] s_next, t_next, s_fin, t_fin;

  always_comb begin
    if (deg_m.pt1) begin
      s_next = '0;
      t_next = deg_m.pt2 ? '0 : te_m;
    end else if (deg_m.pt2) begin
      s_next = sa_m;
      t_next = '0;
    end else if (tcls_d[1]) begin
      s_next = sa_m;
      t_next = '0;
    end else if (tcls_d[0]) begin
      s_next = sb_m;
      t_next = ONE;
    end else begin
      s_next = smid_m;
      t_next = tq;
    end
  end

  always_ff @(posedge clk) begin
    s_fin <= s_next;
    t_fin <= t_next;
  end

  // Stages F+1 and F+2: nearest points.
  logic [6*DW-1:0] dd_d;
  logic [6*CB-1:0] pp_d;

  sscp_delay #(.W(6*DW), .N(F-1)) u_dl_d (
    .clk(clk),
    .d({d1_r[0], d1_r[1], d1_r[2], d2_r[0], d2_r[1], d2_r[2]}),
    .q(dd_d)
  );
  sscp_delay #(.W(6*CB), .N(F)) u_dl_p (
    .clk(clk),
    .d({p1_r[0], p1_r[1], p1_r[2], p2_r[0], p2_r[1], p2_r[2]}),
    .q(pp_d)
  );

  logic signed [SP_W-1:0] sp1 [3];
  logic signed [SP_W-1:0] sp2 [3];
  logic signed [SP_W-1:0] half;

  assign half = SP_W'(1) <<< (P - 1);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sp1[k] <= $signed(dd_d[(5-k)*DW +: DW]) * $signed({1'b0, s_fin});
      sp2[k] <= $signed(dd_d[(2-k)*DW +: DW]) * $signed({1'b0, t_fin});
    end
  end

  // Rounded to nearest, ties toward positive infinity.
  logic signed [CB-1:0] n1_r [3];
  logic signed [CB-1:0] n2_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n1_r[k] <= $signed(pp_d[(5-k)*CB +: CB]) + CB'((sp1[k] + half) >>> P);
      n2_r[k] <= $signed(pp_d[(2-k)*CB +: CB]) + CB'((sp2[k] + half) >>> P);
    end
  end

  // Stages F+3 to F+5: squared distance.
  logic signed [DW-1:0] dc_r [3];
  logic signed [PW-1:0] sq_r [3];
  logic signed [SUM_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dc_r[k] <= DW'(n1_r[k]) - DW'(n2_r[k]);
      sq_r[k] <= dc_r[k] * dc_r[k];
    end
    dist_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  logic [2*SW-1:0] st_o;
  logic [6*CB-1:0] near_o;

  sscp_delay #(.W(2*SW), .N(5)) u_dl_st (.clk(clk), .d({s_fin, t_fin}), .q(st_o));
  sscp_delay #(.W(6*CB), .N(3)) u_dl_near (
    .clk(clk),
    .d({n1_r[0], n1_r[1], n1_r[2], n2_r[0], n2_r[1], n2_r[2]}),
    .q(near_o)
  );

  assign param_s = st_o[2*SW-1:SW];
  assign param_t = st_o[SW-1:0];
  assign near1_x = $signed(near_o[6*CB-1:5*CB]);
  assign near1_y = $signed(near_o[5*CB-1:4*CB]);
  assign near1_z = $signed(near_o[4*CB-1:3*CB]);
  assign near2_x = $signed(near_o[3*CB-1:2*CB]);
  assign near2_y = $signed(near_o[2*CB-1:CB]);
  assign near2_z = $signed(near_o[CB-1:0]);

  // A distance beyond 64 bits saturates to 64 ones.
  if (SUM_W > 64) begin : g_sat
    assign dist_sq = (|dist_r[SUM_W-1:64]) ? DIST_W'({64{1'b1}}) : DIST_W'(dist_r);
  end else begin : g_nosat
    assign dist_sq = DIST_W'(dist_r);
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(TOT) done)
    else $error("item did not produce a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(accept, TOT) |-> !done)
    else $error("result without a matching item");

  a_param_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (param_s <= ONE) && (param_t <= ONE))
    else $error("s or t outside [0,1]");
`endif

endmodule

// ===== dv/tb_segment_segment_closest_points_unit.sv =====
// Self-checking testbench for the segment closest-points unit.
`timescale 1ns / 100ps

module tb_segment_segment_closest_points_unit;
  import sscp_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int FB = DEF_PARAM_FRAC_BITS;
  localparam int LATENCY = 2 * FB + 18;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1420;

  typedef logic signed [CB-1:0] coord_t;
  typedef coord_t seg_pair_t [12];
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [FB:0] s;
    logic [FB:0] t;
    logic [5:0][CB-1:0] near;
    logic [2*CB+1:0] dsq;
  } closest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEGENERATE_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;
  coord_t drv [12] = '{default: '0};
  logic done;
  logic [FB:0] param_s, param_t;
  coord_t near1_x, near1_y, near1_z, near2_x, near2_y, near2_z;
  logic [2*CB+1:0] dist_sq;

  logic [CFG_W-1:0] degen_lim = DEGENERATE_LIMIT_RST;
  logic [CFG_W-1:0] par_lim = PARALLEL_LIMIT_RST;
  closest_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  segment_segment_closest_points_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .p1_x(drv[0]), .p1_y(drv[1]), .p1_z(drv[2]),
    .q1_x(drv[3]), .q1_y(drv[4]), .q1_z(drv[5]),
    .p2_x(drv[6]), .p2_y(drv[7]), .p2_z(drv[8]),
    .q2_x(drv[9]), .q2_y(drv[10]), .q2_z(drv[11]),
    .done(done), .param_s(param_s), .param_t(param_t),
    .near1_x(near1_x), .near1_y(near1_y), .near1_z(near1_z),
    .near2_x(near2_x), .near2_y(near2_y), .near2_z(near2_z),
    .dist_sq(dist_sq)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Clamped quotient in Q1.FB; den is positive.
  function automatic wide_t clamp_quot(wide_t num, wide_t den);
    if (num <= 0) return 0;
    if (num >= den) return wide_t'(1) <<< FB;
    return (num <<< FB) / den;
  endfunction

  function automatic wide_t dot3(wide_t u [3], wide_t v [3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic closest_t closest_points(seg_pair_t v);
    wide_t p1 [3], p2 [3], d1 [3], d2 [3], r [3], n1 [3], n2 [3], dc [3];
    wide_t a, b, c, e, f, denom, tnom, eq, s, t, dsq, dl, pl;
    closest_t res;
    for (int k = 0; k < 3; k++) begin
      p1[k] = v[k];
      p2[k] = v[6+k];
      d1[k] = wide_t'(v[3+k]) - p1[k];
      d2[k] = wide_t'(v[9+k]) - p2[k];
      r[k] = p1[k] - p2[k];
    end
    a = dot3(d1, d1);
    e = dot3(d2, d2);
    b = dot3(d1, d2);
    c = dot3(d1, r);
    f = dot3(d2, r);
    dl = {176'b0, degen_lim};
    pl = {176'b0, par_lim};
    s = 0;
    t = 0;
    if (a <= dl && e <= dl) begin
      s = 0;
    end else if (a <= dl) begin
      t = clamp_quot(f, e);
    end else if (e <= dl) begin
      s = clamp_quot(-c, a);
    end else begin
      denom = a * e - b * b;
      if (denom > 0 && denom >= pl) s = clamp_quot(b * f - c * e, denom);
      tnom = b * s + (f <<< FB);
      eq = e <<< FB;
      if (tnom < 0) begin
        t = 0;
        s = clamp_quot(-c, a);
      end else if (tnom > eq) begin
        t = wide_t'(1) <<< FB;
        s = clamp_quot(b - c, a);
      end else begin
        t = clamp_quot(tnom, eq);
      end
    end
    for (int k = 0; k < 3; k++) begin
      // Rounded to nearest, ties upward.
      n1[k] = p1[k] + ((d1[k] * s + (wide_t'(1) <<< (FB - 1))) >>> FB);
      n2[k] = p2[k] + ((d2[k] * t + (wide_t'(1) <<< (FB - 1))) >>> FB);
      dc[k] = n1[k] - n2[k];
      res.near[k] = n1[k][CB-1:0];
      res.near[3+k] = n2[k][CB-1:0];
    end
    dsq = dot3(dc, dc);
    res.s = s[FB:0];
    res.t = t[FB:0];
    res.dsq = dsq[2*CB+1:0];
    return res;
  endfunction

  task automatic send_pair(seg_pair_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    for (int k = 0; k < 12; k++) drv[k] <= v[k];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(closest_points(v));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEGENERATE_LIMIT) degen_lim = val;
    else par_lim = val;
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic seg_pair_t make_pair(coord_t p1 [3], coord_t q1 [3],
                                         coord_t p2 [3], coord_t q2 [3]);
    seg_pair_t v;
    for (int k = 0; k < 3; k++) begin
      v[k] = p1[k];
      v[3+k] = q1[k];
      v[6+k] = p2[k];
      v[9+k] = q2[k];
    end
    return v;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t v;
    int kind, span, mult;
    kind = $urandom_range(0, 9);
    span = (kind < 2) ? 0 : ($urandom_range(0, 2) == 0 ? 300 :
                             ($urandom_range(0, 1) ? 5000 : 200000));
    for (int k = 0; k < 12; k++) v[k] = rand_coord(span);
    case (kind)
      6: begin
        // Parallel or anti-parallel pair; a zero multiple makes the second a point.
        mult = int'($urandom_range(0, 6)) - 3;
        for (int k = 0; k < 3; k++) begin
          v[3+k] = v[k] + rand_coord(1000);
          v[9+k] = v[6+k] + coord_t'(mult * (v[3+k] - v[k]));
        end
      end
      7: begin
        for (int k = 0; k < 3; k++) begin
          if (v[0][0]) v[3+k] = v[k] + coord_t'($urandom_range(0, 1));
          else v[9+k] = v[6+k] + coord_t'($urandom_range(0, 1));
        end
      end
      8: for (int k = 0; k < 3; k++) begin
        v[3+k] = v[k];
        v[9+k] = v[6+k];
      end
      9: for (int k = 0; k < 3; k++) begin
        // Second segment on the line of the first.
        v[6+k] = v[k] + coord_t'(2 * (v[3+k] - v[k]) / 3);
        v[9+k] = v[k] - coord_t'((v[3+k] - v[k]) / 2);
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    closest_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result s=%0h t=%0h", $time, param_s, param_t);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.s !== param_s) begin
          $display("%0t param_s exp %0h got %0h", $time, want.s, param_s);
          errors++;
        end
        if (want.t !== param_t) begin
          $display("%0t param_t exp %0h got %0h", $time, want.t, param_t);
          errors++;
        end
        if (want.near !== {near2_z, near2_y, near2_x, near1_z, near1_y, near1_x}) begin
          $display("%0t near points exp %h got %h", $time, want.near,
                   {near2_z, near2_y, near2_x, near1_z, near1_y, near1_x});
          errors++;
        end
        if (want.dsq !== dist_sq) begin
          $display("%0t dist_sq exp %0h got %0h", $time, want.dsq, dist_sq);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes;
    coord_t hi [3] = '{default: 24'sh7fffff};
    coord_t lo [3] = '{default: -24'sh800000};
    coord_t zr [3] = '{default: 24'sh0};
    send_pair(make_pair(lo, hi, hi, lo));
    send_pair(make_pair(hi, lo, lo, hi));
    send_pair(make_pair(lo, hi, lo, hi));
    send_pair(make_pair(hi, hi, lo, lo));
    send_pair(make_pair(zr, zr, zr, zr));
    send_pair(make_pair(lo, lo, hi, hi));
  endtask

  task automatic test_special_cases;
    // Both points, first a point, second a point.
    send_pair(make_pair('{10, 20, 30}, '{10, 20, 30}, '{-5, 0, 7}, '{-5, 0, 7}));
    send_pair(make_pair('{0, 0, 0}, '{0, 0, 0}, '{-512, 256, 0}, '{512, 256, 0}));
    send_pair(make_pair('{-512, 0, 0}, '{512, 0, 0}, '{100, 300, 9}, '{100, 300, 9}));
    // Parallel segments.
    send_pair(make_pair('{0, 0, 0}, '{1024, 0, 0}, '{256, 256, 0}, '{2048, 256, 0}));
    send_pair(make_pair('{0, 0, 0}, '{1024, 0, 0}, '{4096, 256, 0}, '{-2048, 256, 0}));
    // Crossing, t below zero, t above one.
    send_pair(make_pair('{-512, 0, 0}, '{512, 0, 0}, '{0, -512, 256}, '{0, 512, 256}));
    send_pair(make_pair('{-512, 0, 0}, '{512, 0, 0}, '{0, 600, 256}, '{0, 2000, 256}));
    send_pair(make_pair('{-512, 0, 0}, '{512, 0, 0}, '{3000, -2000, 9}, '{3000, -600, 9}));
    send_pair(make_pair('{0, 0, 0}, '{300, 0, 0}, '{900, -40, 5}, '{1800, 40, 5}));
    send_pair(make_pair('{0, 0, 0}, '{1, 0, 0}, '{5, 5, 5}, '{6, 5, 5}));
  endtask

  task automatic test_zero_limits;
    write_limit(REG_DEGENERATE_LIMIT, '0);
    write_limit(REG_PARALLEL_LIMIT, '0);
    send_pair(make_pair('{7, 7, 7}, '{7, 7, 7}, '{0, 0, 0}, '{1, 0, 0}));
    send_pair(make_pair('{0, 0, 0}, '{1, 0, 0}, '{3, 3, 3}, '{3, 3, 3}));
    send_pair(make_pair('{1, 1, 1}, '{1, 1, 1}, '{2, 2, 2}, '{2, 2, 2}));
    send_pair(make_pair('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{2, 1, 0}));
    write_limit(REG_DEGENERATE_LIMIT, '1);
    write_limit(REG_PARALLEL_LIMIT, '1);
    send_pair(make_pair('{0, 0, 0}, '{255, 0, 0}, '{0, 9, 0}, '{0, 200, 0}));
    send_pair(make_pair('{0, 0, 0}, '{256, 0, 0}, '{0, 9, 0}, '{0, 256, 0}));
    send_pair(make_pair('{0, 0, 0}, '{300, 100, 0}, '{9, 9, 9}, '{400, 0, 9}));
  endtask

  task automatic test_random_traffic;
    logic [CFG_W-1:0] limit_sets [5][2] = '{'{1, 1}, '{0, 0}, '{16'hffff, 16'hffff},
                                           '{0, 16'hffff}, '{16'h00ff, 16'h0007}};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 5) begin
        write_limit(REG_DEGENERATE_LIMIT, limit_sets[phase][0]);
        write_limit(REG_PARALLEL_LIMIT, limit_sets[phase][1]);
      end else begin
        write_limit(REG_DEGENERATE_LIMIT, CFG_W'($urandom));
        write_limit(REG_PARALLEL_LIMIT, CFG_W'($urandom));
      end
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) send_pair(random_pair());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_zero_limits();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
